FILE: hw/rtl/snapshot_rle_block_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// snapshot_rle_block_decoder_top_assert.svh
// assertion macros used by the checker file of the decoder
// ----------------------------------------------------------------------------
`ifndef SNAPSHOT_RLE_BLOCK_DECODER_TOP_ASSERT_SVH
`define SNAPSHOT_RLE_BLOCK_DECODER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SRBD_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srbd assertion failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SRBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srbd assertion failed");

`endif

FILE: hw/rtl/srbd_pkg.sv
// ----------------------------------------------------------------------------
// srbd_pkg
// shared types and constants of the snapshot rle block decoder
// ----------------------------------------------------------------------------
package srbd_pkg;

  localparam int unsigned RAW_BLOCK_SIZE = 16384;

  // consumed byte counter saturates at 2**16
  localparam int unsigned         CONS_W   = 17;
  localparam logic [CONS_W-1:0]   CONS_CAP = CONS_W'(65536);

  localparam logic [7:0]  TOKEN_ED     = 8'hed;
  localparam logic [14:0] RAW_MARK_LEN = 15'd16384;

  // command queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // fills one byte can cause before splitting
  localparam int unsigned NFILL = 3;

  // register indexes
  localparam int unsigned  REG_IDX_W = 3;
  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_START = 3'd1;
  localparam logic [2:0] REG_BLEN  = 3'd2;
  localparam logic [2:0] REG_STACK = 3'd3;
  localparam logic [2:0] REG_PCL   = 3'd4;
  localparam logic [2:0] REG_PCH   = 3'd5;

  typedef enum logic [1:0] {
    MODE_RAW    = 2'd0,
    MODE_MARKER = 2'd1,
    MODE_LENGTH = 2'd2,
    MODE_ALT    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ED1,
    PH_COUNT,
    PH_VALUE,
    PH_Z1,
    PH_Z2,
    PH_Z3
  } phase_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] start_address;
    logic [14:0] block_length;
    logic [15:0] stack_address;
    logic [7:0]  pc_low;
    logic [7:0]  pc_high;
  } cfg_t;

  // one accepted byte turned into fill work
  typedef struct packed {
    logic                  restart;
    logic                  done;
    logic [1:0]            nfill;
    logic [7:0]            count0;
    logic [NFILL-1:0][7:0] vals;
  } cmd_t;

endpackage

FILE: hw/rtl/srbd_regs.sv
// ----------------------------------------------------------------------------
// srbd_regs
// apb register file holding the decoder configuration
// ----------------------------------------------------------------------------
module srbd_regs
  import srbd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t            cfg_q, cfg_d;
  logic            wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_MODE:  cfg_d.mode          = pwdata[1:0];
        REG_START: cfg_d.start_address = pwdata[15:0];
        REG_BLEN:  cfg_d.block_length  = pwdata[14:0];
        REG_STACK: cfg_d.stack_address = pwdata[15:0];
        REG_PCL:   cfg_d.pc_low        = pwdata[7:0];
        REG_PCH:   cfg_d.pc_high       = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:  prdata = {30'd0, cfg_q.mode};
      REG_START: prdata = {16'd0, cfg_q.start_address};
      REG_BLEN:  prdata = {17'd0, cfg_q.block_length};
      REG_STACK: prdata = {16'd0, cfg_q.stack_address};
      REG_PCL:   prdata = {24'd0, cfg_q.pc_low};
      REG_PCH:   prdata = {24'd0, cfg_q.pc_high};
      default:   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode          <= MODE_MARKER;
      cfg_q.start_address <= 16'd16384;
      cfg_q.block_length  <= RAW_MARK_LEN;
      cfg_q.stack_address <= 16'd0;
      cfg_q.pc_low        <= 8'd0;
      cfg_q.pc_high       <= 8'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: hw/rtl/srbd_front.sv
// ----------------------------------------------------------------------------
// srbd_front
// token decoder: an accepted byte gives at most one fill command
// ----------------------------------------------------------------------------
module srbd_front
  import srbd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] byte_i,
  input  logic       first_i,
  input  logic       q_full_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o
);

  phase_e            phase_q, phase_d, phase_cur;
  logic [7:0]        run_q, run_d;
  logic [CONS_W-1:0] cons_q, cons_d, cons_cur, cons_nx;
  logic              fin_q, fin_d, fin_cur;
  logic              accept;
  logic [1:0]        em;
  logic              raw;
  logic              done;
  logic [1:0]        nf;
  logic [7:0]        cnt0;
  logic [NFILL-1:0][7:0] vals;

  function automatic phase_e boundary_phase(logic [7:0] b, logic [1:0] m);
    if (m == MODE_MARKER && b == 8'h00) begin
      return PH_Z1;
    end else if (b == TOKEN_ED) begin
      return PH_ED1;
    end
    return PH_IDLE;
  endfunction

  assign ready_o = !q_full_i;
  assign accept  = valid_i & ready_o;

  always_comb begin
    phase_cur = first_i ? PH_IDLE : phase_q;
    cons_cur  = first_i ? '0 : cons_q;
    fin_cur   = first_i ? 1'b0 : fin_q;
    em        = (cfg_i.mode == MODE_ALT) ? MODE_RAW : cfg_i.mode;
    raw       = (em == MODE_RAW) || (em == MODE_LENGTH && cfg_i.block_length == RAW_MARK_LEN);
    cons_nx   = (cons_cur < CONS_CAP) ? cons_cur + CONS_W'(1) : cons_cur;

    phase_d = phase_cur;
    run_d   = run_q;
    cons_d  = cons_cur;
    done    = 1'b0;
    nf      = 2'd0;
    cnt0    = 8'd1;
    vals    = '0;

    if (!fin_cur) begin
      if (em == MODE_LENGTH && !raw && cons_cur >= {2'b00, cfg_i.block_length}) begin
        done = 1'b1;
      end else begin
        cons_d = cons_nx;
        if (raw) begin
          phase_d  = PH_IDLE;
          vals[0]  = byte_i;
          nf       = 2'd1;
          if (em == MODE_LENGTH && cons_nx >= CONS_W'(RAW_BLOCK_SIZE)) begin
            done = 1'b1;
          end
        end else begin
          case (phase_cur)
            PH_ED1: begin
              if (byte_i == TOKEN_ED) begin
                phase_d = PH_COUNT;
              end else begin
                vals[0] = TOKEN_ED;
                nf      = 2'd1;
                phase_d = boundary_phase(byte_i, em);
                if (phase_d == PH_IDLE) begin
                  vals[1] = byte_i;
                  nf      = 2'd2;
                end
              end
            end
            PH_COUNT: begin
              run_d   = byte_i;
              phase_d = PH_VALUE;
            end
            PH_VALUE: begin
              phase_d = PH_IDLE;
              vals[0] = byte_i;
              cnt0    = run_q;
              // zero run fills nothing
              nf      = (run_q != 8'd0) ? 2'd1 : 2'd0;
            end
            PH_Z1: begin
              if (byte_i == TOKEN_ED) begin
                phase_d = PH_Z2;
              end else begin
                vals[0] = 8'h00;
                nf      = 2'd1;
                phase_d = boundary_phase(byte_i, em);
                if (phase_d == PH_IDLE) begin
                  vals[1] = byte_i;
                  nf      = 2'd2;
                end
              end
            end
            PH_Z2: begin
              if (byte_i == TOKEN_ED) begin
                phase_d = PH_Z3;
              end else begin
                vals[0] = 8'h00;
                vals[1] = TOKEN_ED;
                nf      = 2'd2;
                phase_d = boundary_phase(byte_i, em);
                if (phase_d == PH_IDLE) begin
                  vals[2] = byte_i;
                  nf      = 2'd3;
                end
              end
            end
            PH_Z3: begin
              if (byte_i == 8'h00 && em == MODE_MARKER) begin
                phase_d = PH_IDLE;
                done    = 1'b1;
              end else begin
                // held 00 ed ed was a literal 00 then an ed ed run, this byte its count
                vals[0] = 8'h00;
                nf      = 2'd1;
                run_d   = byte_i;
                phase_d = PH_VALUE;
              end
            end
            default: begin
              phase_d = boundary_phase(byte_i, em);
              if (phase_d == PH_IDLE) begin
                vals[0] = byte_i;
                nf      = 2'd1;
              end
            end
          endcase

          // length reached mid token: flush held bytes as literals
          if (em == MODE_LENGTH && cons_nx >= {2'b00, cfg_i.block_length}) begin
            done = 1'b1;
            case (phase_d)
              PH_ED1: begin
                vals[nf] = TOKEN_ED;
                nf       = nf + 2'd1;
              end
              PH_Z1, PH_Z3: begin
                vals[nf] = 8'h00;
                nf       = nf + 2'd1;
              end
              PH_Z2: begin
                vals[nf]        = 8'h00;
                vals[nf + 2'd1] = TOKEN_ED;
                nf              = nf + 2'd2;
              end
              default: ;
            endcase
            phase_d = PH_IDLE;
          end
        end
      end
    end

    fin_d = fin_cur | done;
  end

  always_comb begin
    cmd_o.restart = first_i;
    cmd_o.done    = done;
    cmd_o.nfill   = nf;
    cmd_o.count0  = cnt0;
    cmd_o.vals    = vals;
    cmd_valid_o   = accept & (first_i | done | (nf != 2'd0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      run_q   <= 8'd0;
      cons_q  <= '0;
      fin_q   <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      run_q   <= run_d;
      cons_q  <= cons_d;
      fin_q   <= fin_d;
    end
  end

endmodule

FILE: hw/rtl/srbd_fifo.sv
// ----------------------------------------------------------------------------
// srbd_fifo
// short command queue between the token decoder and the segment writer
// ----------------------------------------------------------------------------
module srbd_fifo
  import srbd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t data_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & !full_o;
  assign do_pop  = pop_i & !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + QPTR_W'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QPTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (QPTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: hw/rtl/srbd_back.sv
// ----------------------------------------------------------------------------
// srbd_back
// segment writer: tracks the write address, splits fills around the stack
// bytes and drives the output register
// ----------------------------------------------------------------------------
module srbd_back
  import srbd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_address_o,
  output logic [7:0]  out_value_o,
  output logic [7:0]  out_count_o,
  output logic        out_last_o,
  output logic        out_done_o
);

  logic        busy_q, busy_d;
  cmd_t        cmd_q, cmd_d;
  logic [1:0]  idx_q, idx_d;
  logic [7:0]  rem_q, rem_d;
  logic [15:0] wa_q, wa_d;

  logic        ov_q, ov_d;
  logic [15:0] oaddr_q, oaddr_d;
  logic [7:0]  oval_q, oval_d;
  logic [7:0]  ocnt_q, ocnt_d;
  logic        olast_q, olast_d;
  logic        odone_q, odone_d;

  logic        out_free;
  logic [15:0] sp0, sp1, d0, d1;
  logic        at_sp0, at_sp1;
  logic [7:0]  len, sval, rem_left;
  logic        fill_last;

  assign out_free = !ov_q || out_ready_i;

  // one segment of the current fill
  always_comb begin
    sp0    = cfg_i.stack_address;
    sp1    = sp0 + 16'd1;
    d0     = sp0 - wa_q;
    d1     = sp1 - wa_q;
    at_sp0 = (wa_q == sp0);
    at_sp1 = (wa_q == sp1);
    len    = rem_q;
    if (d0 < {8'd0, len}) begin
      len = d0[7:0];
    end
    if (d1 < {8'd0, len}) begin
      len = d1[7:0];
    end
    if (at_sp0) begin
      len  = 8'd1;
      sval = cfg_i.pc_low;
    end else if (at_sp1) begin
      len  = 8'd1;
      sval = cfg_i.pc_high;
    end else begin
      sval = cmd_q.vals[idx_q];
    end
    rem_left  = rem_q - len;
    fill_last = (idx_q == cmd_q.nfill - 2'd1);
  end

  always_comb begin
    busy_d    = busy_q;
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    rem_d     = rem_q;
    wa_d      = wa_q;
    cmd_pop_o = 1'b0;
    ov_d      = ov_q && !out_ready_i;
    oaddr_d   = oaddr_q;
    oval_d    = oval_q;
    ocnt_d    = ocnt_q;
    olast_d   = olast_q;
    odone_d   = odone_q;

    if (!busy_q) begin
      if (cmd_valid_i) begin
        cmd_pop_o = 1'b1;
        busy_d    = 1'b1;
        cmd_d     = cmd_i;
        idx_d     = 2'd0;
        rem_d     = cmd_i.count0;
        if (cmd_i.restart) begin
          wa_d = cfg_i.start_address;
        end
      end
    end else if (cmd_q.nfill == 2'd0) begin
      if (!cmd_q.done) begin
        busy_d = 1'b0;
      end else if (out_free) begin
        // block ended without filling anything
        ov_d    = 1'b1;
        oaddr_d = wa_q;
        oval_d  = 8'd0;
        ocnt_d  = 8'd0;
        olast_d = 1'b1;
        odone_d = 1'b1;
        busy_d  = 1'b0;
      end
    end else if (out_free) begin
      ov_d    = 1'b1;
      oaddr_d = wa_q;
      oval_d  = sval;
      ocnt_d  = len;
      olast_d = (rem_left == 8'd0) && fill_last;
      odone_d = cmd_q.done;
      wa_d    = wa_q + {8'd0, len};
      if (rem_left == 8'd0) begin
        if (fill_last) begin
          busy_d = 1'b0;
        end else begin
          idx_d = idx_q + 2'd1;
          rem_d = 8'd1;
        end
      end else begin
        rem_d = rem_left;
      end
    end
  end

  assign out_valid_o   = ov_q;
  assign out_address_o = oaddr_q;
  assign out_value_o   = oval_q;
  assign out_count_o   = ocnt_q;
  assign out_last_o    = olast_q;
  assign out_done_o    = odone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
      wa_q   <= 16'd16384;
    end else begin
      busy_q <= busy_d;
      ov_q   <= ov_d;
      wa_q   <= wa_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    idx_q   <= idx_d;
    rem_q   <= rem_d;
    oaddr_q <= oaddr_d;
    oval_q  <= oval_d;
    ocnt_q  <= ocnt_d;
    olast_q <= olast_d;
    odone_q <= odone_d;
  end

endmodule

FILE: hw/rtl/snapshot_rle_block_decoder_top.sv
// ----------------------------------------------------------------------------
// snapshot_rle_block_decoder_top
// ed ed run-length snapshot block decoder giving memory fill segments
// ----------------------------------------------------------------------------
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid / s_axis_tready    tdata byte, tuser first
// m_axis    out  m_axis_tvalid / m_axis_tready    tdata addr/value/count,
//                                                 tlast last, tuser block_done
// apb       in   psel & penable & pwrite          six config registers
//
// the token decoder takes one byte per cycle while the command queue has room
// the segment writer loads a command, then writes one segment of it whenever the
// output register is free, and takes no new command until its last one is out;
// held marker and ed bytes make no command
// reset puts the write address at 16384 and clears decode state, no sweep
// a stalled output holds in its register while the 4-entry queue fills
// ----------------------------------------------------------------------------
module snapshot_rle_block_decoder_top
  import srbd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] first
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] address, [23:16] value, [31:24] count
  output logic        m_axis_tlast,   // last
  output logic        m_axis_tuser,   // [0] block_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t        cfg;
  cmd_t        cmd_in, cmd_out;
  logic        cmd_push, q_full, q_empty, cmd_pop;
  logic [15:0] out_address;
  logic [7:0]  out_value, out_count;

  srbd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  srbd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .byte_i      (s_axis_tdata),
    .first_i     (s_axis_tuser),
    .q_full_i    (q_full),
    .cmd_valid_o (cmd_push),
    .cmd_o       (cmd_in)
  );

  srbd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .pop_i   (cmd_pop),
    .empty_o (q_empty),
    .data_o  (cmd_out)
  );

  srbd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_valid_i   (!q_empty),
    .cmd_i         (cmd_out),
    .cmd_pop_o     (cmd_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_address_o (out_address),
    .out_value_o   (out_value),
    .out_count_o   (out_count),
    .out_last_o    (m_axis_tlast),
    .out_done_o    (m_axis_tuser)
  );

  assign m_axis_tdata = {out_count, out_value, out_address};

endmodule

FILE: hw/rtl/srbd_checker.sv
// ----------------------------------------------------------------------------
// srbd_checker
// port-level checks on the decoder output stream
// ----------------------------------------------------------------------------
`include "snapshot_rle_block_decoder_top_assert.svh"

module srbd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // a stalled segment stays put
  `SRBD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))

  // an empty segment only marks the end of a block, alone
  `SRBD_ASSERT_IMPLY(a_empty_is_end, m_axis_tvalid && m_axis_tdata[31:24] == 8'd0, m_axis_tlast && m_axis_tuser)

  // an empty segment carries value zero
  `SRBD_ASSERT_IMPLY(a_empty_value, m_axis_tvalid && m_axis_tdata[31:24] == 8'd0, m_axis_tdata[23:16] == 8'd0)

endmodule

bind snapshot_rle_block_decoder_top srbd_checker u_checker (.*);

FILE: sim/srbd_sb_pkg.sv
// ----------------------------------------------------------------------------
// srbd_sb_pkg
// fill segment predictor and scoreboard for the snapshot rle block decoder
// ----------------------------------------------------------------------------
// keeps its own copy of the six registers and the decode state, turns every
// accepted byte into the fill segments it should cause, and checks the
// segments coming out of the block in order against them
// ----------------------------------------------------------------------------
package srbd_sb_pkg;
  import srbd_pkg::*;

  localparam int unsigned MAX_SEGS = 4;
  localparam int unsigned SHOWN_MISMATCHES = 10;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  value;
    logic [7:0]  count;
    logic        last;
    logic        done;
  } fill_seg_t;

  class segment_scoreboard;
    // register copy
    mode_e       mode;
    logic [15:0] start_addr;
    logic [14:0] blen;
    logic [15:0] stack_addr;
    logic [7:0]  pc_lo;
    logic [7:0]  pc_hi;

    // decode state
    logic [15:0] waddr;
    int unsigned consumed;
    phase_e      phase;
    logic [7:0]  run_len;
    bit          finished;

    fill_seg_t   step_segs[$];
    fill_seg_t   pending_segs[$];
    int unsigned failures;

    function new();
      mode       = MODE_MARKER;
      start_addr = 16'd16384;
      blen       = RAW_MARK_LEN;
      stack_addr = 16'h0000;
      pc_lo      = 8'h00;
      pc_hi      = 8'h00;
      failures   = 0;
      restart();
    endfunction

    function void restart();
      waddr    = start_addr;
      consumed = 0;
      phase    = PH_IDLE;
      run_len  = 8'h00;
      finished = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_MODE:  mode       = mode_e'(v[1:0]);
        REG_START: start_addr = v[15:0];
        REG_BLEN:  blen       = v[14:0];
        REG_STACK: stack_addr = v[15:0];
        REG_PCL:   pc_lo      = v[7:0];
        REG_PCH:   pc_hi      = v[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending_count();
      return pending_segs.size();
    endfunction

    function bit block_finished();
      return finished;
    endfunction

    function void emit(logic [15:0] a, logic [7:0] v, logic [7:0] n);
      fill_seg_t s;
      if (step_segs.size() >= MAX_SEGS) return;
      s.addr  = a;
      s.value = v;
      s.count = n;
      s.last  = 1'b0;
      s.done  = 1'b0;
      step_segs.push_back(s);
    endfunction

    // split around the two patched stack bytes
    function void fill(logic [7:0] val, int unsigned cnt);
      logic [15:0] sp0, sp1, a, d0, d1;
      int unsigned len;
      sp0 = stack_addr;
      sp1 = stack_addr + 16'd1;
      while (cnt > 0) begin
        a   = waddr;
        len = cnt;
        if (a == sp0) begin
          emit(a, pc_lo, 8'd1);
          len = 1;
        end else if (a == sp1) begin
          emit(a, pc_hi, 8'd1);
          len = 1;
        end else begin
          d0 = sp0 - a;
          d1 = sp1 - a;
          if (d0 < len) len = d0;
          if (d1 < len) len = d1;
          emit(a, val, 8'(len));
        end
        waddr = a + 16'(len);
        cnt  -= len;
      end
    endfunction

    function void boundary(logic [7:0] b, bit marker);
      phase = PH_IDLE;
      if (marker && b == 8'h00) phase = PH_Z1;
      else if (b == TOKEN_ED) phase = PH_ED1;
      else fill(b, 1);
    endfunction

    function void take_byte(logic [7:0] b, logic first);
      mode_e eff;
      bit    raw, marker, done;
      if (first) restart();
      if (finished) return;
      step_segs.delete();
      done   = 0;
      eff    = (mode == MODE_ALT) ? MODE_RAW : mode;
      raw    = (eff == MODE_RAW) || (eff == MODE_LENGTH && blen == RAW_MARK_LEN);
      marker = (eff == MODE_MARKER);
      if (eff == MODE_LENGTH && !raw && consumed >= blen) begin
        done = 1;
      end else begin
        if (consumed < CONS_CAP) consumed++;
        if (raw) begin
          phase = PH_IDLE;
          fill(b, 1);
          if (eff == MODE_LENGTH && consumed >= RAW_BLOCK_SIZE) done = 1;
        end else begin
          case (phase)
            PH_ED1: begin
              if (b == TOKEN_ED) phase = PH_COUNT;
              else begin
                fill(TOKEN_ED, 1);
                boundary(b, marker);
              end
            end
            PH_COUNT: begin
              run_len = b;
              phase   = PH_VALUE;
            end
            PH_VALUE: begin
              phase = PH_IDLE;
              fill(b, run_len);
            end
            PH_Z1: begin
              if (b == TOKEN_ED) phase = PH_Z2;
              else begin
                fill(8'h00, 1);
                boundary(b, marker);
              end
            end
            PH_Z2: begin
              if (b == TOKEN_ED) phase = PH_Z3;
              else begin
                fill(8'h00, 1);
                fill(TOKEN_ED, 1);
                boundary(b, marker);
              end
            end
            PH_Z3: begin
              if (b == 8'h00 && marker) begin
                phase = PH_IDLE;
                done  = 1;
              end else begin
                fill(8'h00, 1);
                run_len = b;
                phase   = PH_VALUE;
              end
            end
            default: boundary(b, marker);
          endcase
          // length reached inside a token: held bytes go out as literals
          if (eff == MODE_LENGTH && consumed >= blen) begin
            done = 1;
            case (phase)
              PH_ED1:       fill(TOKEN_ED, 1);
              PH_Z1, PH_Z3: fill(8'h00, 1);
              PH_Z2: begin
                fill(8'h00, 1);
                fill(TOKEN_ED, 1);
              end
              default: ;
            endcase
            phase = PH_IDLE;
          end
        end
      end
      if (done) begin
        finished = 1;
        if (step_segs.size() == 0) emit(waddr, 8'h00, 8'h00);
      end
      foreach (step_segs[k]) begin
        step_segs[k].last = (k == step_segs.size() - 1);
        step_segs[k].done = done;
        pending_segs.push_back(step_segs[k]);
      end
    endfunction

    function void flag(string what, fill_seg_t exp, fill_seg_t got);
      failures++;
      if (failures <= SHOWN_MISMATCHES)
        $display("%t %s: exp addr=%h val=%h cnt=%0d last=%b done=%b, got addr=%h val=%h cnt=%0d last=%b done=%b",
                 $realtime, what, exp.addr, exp.value, exp.count, exp.last, exp.done,
                 got.addr, got.value, got.count, got.last, got.done);
    endfunction

    function void check_segment(logic [31:0] tdata, logic tlast, logic tuser);
      fill_seg_t got, exp;
      got.addr  = tdata[15:0];
      got.value = tdata[23:16];
      got.count = tdata[31:24];
      got.last  = tlast;
      got.done  = tuser;
      if (pending_segs.size() == 0) begin
        exp = '0;
        flag("segment with nothing pending", exp, got);
        return;
      end
      exp = pending_segs.pop_front();
      if (got.addr !== exp.addr || got.value !== exp.value || got.count !== exp.count ||
          got.last !== exp.last || got.done !== exp.done)
        flag("segment mismatch", exp, got);
    endfunction

    function void close_out();
      if (pending_segs.size() != 0) begin
        failures += pending_segs.size();
        $display("%0d segments never arrived", pending_segs.size());
      end
    endfunction
  endclass

endpackage

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// testbench for the snapshot rle block decoder
// ----------------------------------------------------------------------------
// drives compressed bytes over the input stream, programs the registers over
// apb between phases, and checks every fill segment against the predictor;
// a directed opening is followed by random token streams under several
// register settings and a short raw block in length mode
// ----------------------------------------------------------------------------
module tb_top;
  import srbd_pkg::*;
  import srbd_sb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned SETTLE_DELAY = 16;
  localparam int unsigned RAND_PHASES  = 7;
  localparam int unsigned PHASE_ITEMS  = 28;
  localparam int unsigned RAW_ITEMS    = 8;

  typedef logic [7:0] byte_q_t[$];

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        s_axis_tuser;   // [0] first
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [15:0] address, [23:16] value, [31:24] count
  logic        m_axis_tlast;   // last
  logic        m_axis_tuser;   // [0] block_done
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  segment_scoreboard sb;
  bit tx_idle;
  bit rx_idle;
  bit rx_hold_req;

  snapshot_rle_block_decoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.take_byte(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_segment(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : sink
    int unsigned stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        stall_left  = HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end else if (stall_left == 0 && rx_idle && $urandom_range(0, 3) == 0) begin
        stall_left = gap_len() + 1;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // entered and left just after a falling edge
  task automatic send_byte(input logic [7:0] b, input logic first);
    int unsigned g;
    g = tx_idle ? gap_len() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    @(negedge clk_i);
  endtask

  task automatic send_bytes(input byte_q_t bytes, input logic first);
    foreach (bytes[k]) send_byte(bytes[k], (k == 0) ? first : 1'b0);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending_count() != 0) @(negedge clk_i);
  endtask

  // held bytes make no segment, so give the block time after the last one
  task automatic settle();
    drain();
    repeat (SETTLE_DELAY) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (pready) break;
    end
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic program_regs(input mode_e m, input logic [15:0] st, input logic [14:0] bl,
                              input logic [15:0] sk, input logic [7:0] pl,
                              input logic [7:0] ph);
    apb_write(REG_MODE, 32'(m));
    apb_write(REG_START, 32'(st));
    apb_write(REG_BLEN, 32'(bl));
    apb_write(REG_STACK, 32'(sk));
    apb_write(REG_PCL, 32'(pl));
    apb_write(REG_PCH, 32'(ph));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_regs();
    mode_e       m;
    logic [15:0] st, sk;
    logic [14:0] bl;
    int unsigned r;
    r  = $urandom_range(0, 99);
    m  = (r < 15) ? MODE_RAW : (r < 50) ? MODE_MARKER : (r < 90) ? MODE_LENGTH : MODE_ALT;
    st = ($urandom_range(0, 3) == 0) ? 16'hfff0 + 16'($urandom_range(0, 15))
                                     : 16'($urandom_range(0, 65535));
    // stack pointer usually just ahead of the block so runs get split
    sk = ($urandom_range(0, 4) != 0) ? st + 16'($urandom_range(0, 24))
                                     : 16'($urandom_range(0, 65535));
    r  = $urandom_range(0, 99);
    bl = (r < 70) ? 15'($urandom_range(0, 40)) :
         (r < 80) ? RAW_MARK_LEN : 15'($urandom_range(0, 32767));
    program_regs(m, st, bl, sk, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // mostly well-formed tokens with random content, some broken ones
  task automatic send_stream(input int unsigned n_items, input bit pause_mid);
    int unsigned taken, r, n;
    logic        f;
    bit          opening, pause_due, skip;
    byte_q_t     tok;
    taken     = 0;
    opening   = 1;
    pause_due = pause_mid;
    while (taken < n_items) begin
      if (pause_due && taken >= n_items / 2) begin
        drain();
        pause_due = 0;
      end
      if (opening) f = ($urandom_range(0, 3) != 0);
      else if (sb.block_finished()) f = ($urandom_range(0, 5) != 0);
      else f = ($urandom_range(0, 60) == 0);
      opening = 0;
      tok.delete();
      r = $urandom_range(0, 99);
      if (sb.block_finished() && !f) begin
        tok.push_back(8'($urandom_range(0, 255)));
      end else if (r < 40) begin
        tok.push_back(8'($urandom_range(0, 255)));
      end else if (r < 70) begin
        n = $urandom_range(0, 9);
        n = (n < 7) ? $urandom_range(1, 6) : (n == 7) ? 0 : (n == 8) ? 255
                                                       : $urandom_range(0, 255);
        tok = '{TOKEN_ED, TOKEN_ED, 8'(n), 8'($urandom_range(0, 255))};
      end else if (r < 80) begin
        tok = '{8'h00, TOKEN_ED, TOKEN_ED,
                ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(0, 255))};
      end else if (r < 90) begin
        tok = '{8'h00, 8'($urandom_range(0, 255))};
        if ($urandom_range(0, 1) == 0) tok.insert(1, TOKEN_ED);
      end else begin
        tok = '{TOKEN_ED, 8'($urandom_range(0, 255))};
      end
      foreach (tok[k]) begin
        skip = sb.block_finished() && !(k == 0 && f);
        send_byte(tok[k], (k == 0) ? f : 1'b0);
        if (!skip) taken++;
      end
    end
  endtask

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    tx_idle       = 0;
    rx_idle       = 0;
    rx_hold_req   = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // marker mode, block wrapping through the stack pair at ffff/0000
    program_regs(MODE_MARKER, 16'hfffe, RAW_MARK_LEN, 16'hffff, 8'h34, 8'h12);
    send_bytes('{TOKEN_ED, TOKEN_ED, 8'hff, 8'h5a}, 1'b1);
    // lone ed, zero run, 00 ed then literal
    send_bytes('{TOKEN_ED, 8'h42, TOKEN_ED, TOKEN_ED, 8'h00, 8'h99, 8'h00, TOKEN_ED, 8'h55},
               1'b0);
    // 00 ed ed n v is a literal 00 and a run, then the end marker and a byte after it
    send_bytes('{8'h00, TOKEN_ED, TOKEN_ED, 8'h03, 8'h66, 8'h00, TOKEN_ED, TOKEN_ED, 8'h00,
                 8'h11}, 1'b0);
    settle();
    // length reached in the middle of a run
    program_regs(MODE_LENGTH, 16'h0000, 15'd2, 16'h0000, 8'hff, 8'h00);
    send_bytes('{TOKEN_ED, TOKEN_ED}, 1'b1);
    settle();
    // zero length ends the block without taking the byte
    program_regs(MODE_LENGTH, 16'h8000, 15'd0, 16'h8000, 8'h00, 8'hff);
    send_bytes('{8'h77}, 1'b1);

    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      if (p == 0) program_regs(MODE_RAW, 16'h0000, 15'd0, 16'h0000, 8'h00, 8'h00);
      else if (p == 1) program_regs(MODE_ALT, 16'hffff, 15'h7fff, 16'hffff, 8'hff, 8'hff);
      else random_regs();
      tx_idle = (p != 0) && ($urandom_range(0, 3) != 0);
      rx_idle = (p != 0) && ($urandom_range(0, 3) != 0);
      if (p == 2) begin
        tx_idle     = 0;
        rx_hold_req = 1;
      end
      send_stream(PHASE_ITEMS, p == 3);
    end

    // an uncompressed block in length mode, ed bytes copied as they are
    settle();
    program_regs(MODE_LENGTH, 16'($urandom_range(0, 65535)), RAW_MARK_LEN,
                 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
    tx_idle = 0;
    rx_idle = 0;
    for (int i = 0; i < RAW_ITEMS; i++)
      send_byte((i % 3 == 1) ? TOKEN_ED : 8'($urandom_range(0, 255)), i == 0);

    drain();
    repeat (30) @(posedge clk_i);
    sb.close_out();
    if (sb.failures == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
